FILE: rtl/snt_pkg.sv
// ----------------------------------------------------------------------------
// snt_pkg: slot name table shared types and constants
// request modes, field widths and the stored entry layout
// ----------------------------------------------------------------------------
package snt_pkg;

    localparam int KEY_W  = 64;
    localparam int POS_W  = 7;
    localparam int NEXT_W = POS_W + 1;

    // highest position that fits the position field
    localparam logic [NEXT_W-1:0] POS_LIMIT = NEXT_W'((1 << POS_W) - 1);

    localparam logic [1:0] MODE_APPEND   = 2'd0;
    localparam logic [1:0] MODE_NAME_AT  = 2'd1;
    localparam logic [1:0] MODE_POS_OF   = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0] class_key;
        logic [KEY_W-1:0] name_key;
        logic [POS_W-1:0] position;
    } t_entry;

endpackage

FILE: rtl/snt_if.sv
// ----------------------------------------------------------------------------
// snt_if: request and response channels of the slot name table
// valid/ready channels, one word accepted when both are high
// ----------------------------------------------------------------------------
interface snt_req_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               mode;
    logic [snt_pkg::KEY_W-1:0] class_key;
    logic [snt_pkg::KEY_W-1:0] name_key;
    logic [snt_pkg::POS_W-1:0] slot_position;

    modport source (output valid, mode, class_key, name_key, slot_position, input ready);
    modport sink   (input valid, mode, class_key, name_key, slot_position, output ready);
endinterface

interface snt_rsp_if;
    logic                     valid;
    logic                     ready;
    logic                     hit;
    logic [snt_pkg::KEY_W-1:0] found_name;
    logic [snt_pkg::POS_W-1:0] found_position;
    logic                     table_full;

    modport source (output valid, hit, found_name, found_position, table_full, input ready);
    modport sink   (input valid, hit, found_name, found_position, table_full, output ready);
endinterface

FILE: rtl/snt_entry_ram.sv
// ----------------------------------------------------------------------------
// snt_entry_ram: entry store of the slot name table
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module snt_entry_ram #(
    parameter int ENTRIES = 128
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(ENTRIES)-1:0] i_wr_addr,
    input  snt_pkg::t_entry            i_wr_data,
    input  logic [$clog2(ENTRIES)-1:0] i_rd_addr,
    output snt_pkg::t_entry            o_rd_data
);

    snt_pkg::t_entry r_mem [ENTRIES];
    snt_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/slot_name_table.sv
// ----------------------------------------------------------------------------
// slot_name_table: table of (class key, name key, slot position) entries
// append, lookup of a name by position and lookup of a position by name
// ----------------------------------------------------------------------------
// usage
//   i_req carries one request word: mode, class key, name key, slot position.
//   o_rsp returns exactly one response word per request: hit, found name,
//   found position, table full.
//   every request sweeps the entry ram one address per cycle through its
//   single read port, compares the registered read word, and stops early on
//   a lookup or duplicate-append hit. with the output register free, the
//   finish step loads the response and goes back to idle, where the next
//   request is taken.
//   one request is worked on at a time; i_req.ready is high only while idle.
//   the response sits in an output register, so a new request is taken while
//   an old response still waits; a stalled receiver only holds the finish
//   step of the following request until the register is free.
//   entries are filled from the top index downward and never removed, so a
//   fill count marks which entries are valid: reset clears the count and the
//   table is empty at once, with no clearing pass over the ram.
// ----------------------------------------------------------------------------
module slot_name_table #(
    parameter int ENTRIES = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    snt_req_if.sink   i_req,
    snt_rsp_if.source o_rsp
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = IW + 1;

    localparam logic [CW-1:0] ENT_C    = CW'(ENTRIES);
    localparam logic [CW:0]   ENT_X    = (CW + 1)'(ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state r_state;

    // latched request
    logic [1:0]                 r_mode;
    logic [snt_pkg::KEY_W-1:0]  r_class;
    logic [snt_pkg::KEY_W-1:0]  r_name_key;
    logic [snt_pkg::POS_W-1:0]  r_slot;

    // scan pipeline: issue address, then compare the registered read word in the next cycle
    logic [CW-1:0]              r_issue;
    logic                       r_chk_vld;
    logic [IW-1:0]              r_chk_idx;

    // scan results
    logic                       r_hit;
    logic [snt_pkg::KEY_W-1:0]  r_name;
    logic [snt_pkg::POS_W-1:0]  r_pos;
    logic [snt_pkg::NEXT_W-1:0] r_next;

    // number of filled entries, at the top of the index range
    logic [CW-1:0]              r_count;

    // output register
    logic                       r_out_vld;
    logic                       r_out_hit;
    logic [snt_pkg::KEY_W-1:0]  r_out_name;
    logic [snt_pkg::POS_W-1:0]  r_out_pos;
    logic                       r_out_full;

    snt_pkg::t_entry            rd_data;
    snt_pkg::t_entry            wr_data;
    logic                       wr_en;
    logic [IW-1:0]              wr_addr;
    logic [IW-1:0]              rd_addr;

    logic                       ent_ok;
    logic                       cls_eq;
    logic                       nm_eq;
    logic                       pos_eq;
    logic                       hit_now;
    logic                       grow_next;
    logic [snt_pkg::NEXT_W-1:0] ent_next;
    logic                       out_free;
    logic                       load_out;
    logic                       is_append;
    logic                       no_room;

    snt_entry_ram #(
        .ENTRIES (ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_addr = r_issue[IW-1:0];

    always_comb begin
        // entry is valid when it lies in the filled top range
        ent_ok    = r_chk_vld
                    && (({1'b0, {1'b0, r_chk_idx}} + {1'b0, r_count}) >= ENT_X);
        cls_eq    = (rd_data.class_key == r_class);
        nm_eq     = (rd_data.name_key == r_name_key);
        pos_eq    = (rd_data.position == r_slot);
        is_append = (r_mode == snt_pkg::MODE_APPEND);
        hit_now   = ent_ok && cls_eq
                    && ((is_append && nm_eq)
                        || ((r_mode == snt_pkg::MODE_NAME_AT) && pos_eq)
                        || ((r_mode == snt_pkg::MODE_POS_OF) && nm_eq));
        ent_next  = {1'b0, rd_data.position} + snt_pkg::NEXT_W'(1);
        grow_next = ent_ok && cls_eq && is_append
                    && ({1'b0, rd_data.position} >= r_next);
        out_free  = !r_out_vld || o_rsp.ready;
        // finish step loads the output register this cycle
        load_out  = (r_state == S_FINISH) && out_free;
        no_room   = (r_count == ENT_C) || (r_next > snt_pkg::POS_LIMIT);
    end

    // append commit: free entry just below the filled range
    always_comb begin
        wr_en             = (r_state == S_FINISH) && out_free && is_append
                            && !r_hit && !no_room;
        wr_addr           = LAST_IDX - r_count[IW-1:0];
        wr_data.class_key = r_class;
        wr_data.name_key  = r_name_key;
        wr_data.position  = r_next[snt_pkg::POS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
            r_chk_vld <= 1'b0;
        end else begin
            if (o_rsp.valid && o_rsp.ready && !load_out) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_mode     <= i_req.mode;
                        r_class    <= i_req.class_key;
                        r_name_key <= i_req.name_key;
                        r_slot     <= i_req.slot_position;
                        r_issue    <= '0;
                        r_chk_vld  <= 1'b0;
                        r_hit      <= 1'b0;
                        r_name     <= '0;
                        r_pos      <= '0;
                        r_next     <= '0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_issue != ENT_C) begin
                        r_issue   <= r_issue + CW'(1);
                        r_chk_vld <= 1'b1;
                        r_chk_idx <= r_issue[IW-1:0];
                    end else begin
                        r_chk_vld <= 1'b0;
                    end
                    priority if (hit_now) begin
                        r_hit   <= 1'b1;
                        r_pos   <= rd_data.position;
                        if (r_mode == snt_pkg::MODE_NAME_AT) begin
                            r_name <= rd_data.name_key;
                        end
                        r_state <= S_FINISH;
                    end else if (!r_chk_vld && (r_issue == ENT_C)) begin
                        r_state <= S_FINISH;
                    end else if (grow_next) begin
                        r_next <= ent_next;
                    end else begin
                        // keep scanning
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out_vld  <= 1'b1;
                        r_out_hit  <= r_hit;
                        r_out_name <= r_name;
                        if (is_append && !r_hit) begin
                            r_out_full <= no_room;
                            r_out_pos  <= no_room ? '0 : r_next[snt_pkg::POS_W-1:0];
                            if (!no_room) begin
                                r_count <= r_count + CW'(1);
                            end
                        end else begin
                            r_out_full <= 1'b0;
                            r_out_pos  <= r_pos;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_out_vld;
    assign o_rsp.hit            = r_out_hit;
    assign o_rsp.found_name     = r_out_name;
    assign o_rsp.found_position = r_out_pos;
    assign o_rsp.table_full     = r_out_full;

endmodule

FILE: rtl/snt_checker.sv
// ----------------------------------------------------------------------------
// snt_checker: port-level checks for the slot name table
// response ordering against requests and response field consistency
// ----------------------------------------------------------------------------
module snt_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_req_valid,
    input logic                      i_req_ready,
    input logic                      i_rsp_valid,
    input logic                      i_rsp_ready,
    input logic                      i_rsp_hit,
    input logic [snt_pkg::KEY_W-1:0] i_rsp_found_name,
    input logic [snt_pkg::POS_W-1:0] i_rsp_found_position,
    input logic                      i_rsp_table_full
);

    logic       req_acc;
    logic       rsp_acc;
    logic [1:0] r_pend;

    assign req_acc = i_req_valid && i_req_ready;
    assign rsp_acc = i_rsp_valid && i_rsp_ready;

    // requests accepted minus responses delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 2'(req_acc) - 2'(rsp_acc);
        end
    end

    a_no_phantom_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (r_pend != 2'd0))
        else $error("response word without an outstanding request");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> !i_req_ready)
        else $error("request taken while the previous one is still at work");

    a_full_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_table_full) |->
            (!i_rsp_hit && (i_rsp_found_name == '0) && (i_rsp_found_position == '0)))
        else $error("table full response carries a hit or a value");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_hit) && $stable(i_rsp_found_name)
             && $stable(i_rsp_found_position) && $stable(i_rsp_table_full)))
        else $error("stalled response word changed");

endmodule

bind slot_name_table snt_checker u_snt_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_req_valid          (i_req.valid),
    .i_req_ready          (i_req.ready),
    .i_rsp_valid          (o_rsp.valid),
    .i_rsp_ready          (o_rsp.ready),
    .i_rsp_hit            (o_rsp.hit),
    .i_rsp_found_name     (o_rsp.found_name),
    .i_rsp_found_position (o_rsp.found_position),
    .i_rsp_table_full     (o_rsp.table_full)
);

FILE: verif/tb_slot_name_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slot_name_table: self-checking bench for the slot name table
// drives request words over a valid/ready channel, predicts every response
// word from a private copy of the table and checks it field by field
// ----------------------------------------------------------------------------
module tb_slot_name_table;

    localparam int ENTRIES      = 128;
    localparam int CLASS_POOL   = 6;
    localparam int IDLE_PCT     = 36;
    localparam int RANDOM_ITEMS = 1750;
    // stretch of the random traffic where neither side idles
    localparam int QUIET_FROM   = 700;
    localparam int QUIET_TO     = 1000;
    // 40 ms, many times the slowest legal run
    localparam int RUN_LIMIT_NS = 40_000_000;

    // mode code the block leaves unused
    localparam logic [1:0]                MODE_UNUSED = 2'd3;
    localparam logic [snt_pkg::KEY_W-1:0] KEY_ONES    = '1;

    typedef struct packed {
        logic [1:0]                mode;
        logic [snt_pkg::KEY_W-1:0] class_key;
        logic [snt_pkg::KEY_W-1:0] name_key;
        logic [snt_pkg::POS_W-1:0] slot_position;
    } t_request;

    typedef struct packed {
        logic                      hit;
        logic [snt_pkg::KEY_W-1:0] found_name;
        logic [snt_pkg::POS_W-1:0] found_position;
        logic                      table_full;
    } t_answer;

    logic i_clk;
    logic i_rst_n;

    snt_req_if req_ch ();
    snt_rsp_if rsp_ch ();

    slot_name_table #(
        .ENTRIES (ENTRIES)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // private copy of the table, kept in step with accepted request words
    logic                      tbl_valid [ENTRIES];
    logic [snt_pkg::KEY_W-1:0] tbl_class [ENTRIES];
    logic [snt_pkg::KEY_W-1:0] tbl_name  [ENTRIES];
    logic [snt_pkg::POS_W-1:0] tbl_pos   [ENTRIES];
    int                        stored_idx [$];

    // response words still owed by the block, oldest first
    t_answer pending_answers [$];

    logic [snt_pkg::KEY_W-1:0] class_pool [CLASS_POOL];
    bit                        no_idle;

    int mismatch_count  = 0;
    int answers_seen    = 0;
    int appends_stored  = 0;
    int appends_repeat  = 0;
    int appends_refused = 0;
    int lookup_hits     = 0;
    int lookup_misses   = 0;

    // ------------------------------------------------------------------------
    // clock and run limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("%0t: run limit reached with %0d words outstanding",
                 $time, pending_answers.size());
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // table predictor: works out the response word for one request word and
    // updates the private table the way the block must
    // ------------------------------------------------------------------------
    function automatic t_answer predict_table_answer(t_request r);
        t_answer                    a;
        logic [snt_pkg::NEXT_W-1:0] next_pos;
        bit                         have_free;
        int                         free_idx;
        a         = '0;
        next_pos  = '0;
        have_free = 1'b0;
        free_idx  = 0;
        case (r.mode)
            snt_pkg::MODE_APPEND: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (tbl_valid[i]) begin
                        if (tbl_class[i] == r.class_key) begin
                            // name already in this class: nothing changes
                            if (tbl_name[i] == r.name_key) begin
                                appends_repeat++;
                                a.hit            = 1'b1;
                                a.found_position = tbl_pos[i];
                                return a;
                            end
                            if (next_pos <= snt_pkg::NEXT_W'(tbl_pos[i]))
                                next_pos = snt_pkg::NEXT_W'(tbl_pos[i])
                                           + snt_pkg::NEXT_W'(1);
                        end
                    end else begin
                        // last free entry seen is the highest free index
                        have_free = 1'b1;
                        free_idx  = i;
                    end
                end
                // no free entry, or the class already holds the top position
                if (!have_free || next_pos > snt_pkg::POS_LIMIT) begin
                    appends_refused++;
                    a.table_full = 1'b1;
                    return a;
                end
                tbl_valid[free_idx] = 1'b1;
                tbl_class[free_idx] = r.class_key;
                tbl_name[free_idx]  = r.name_key;
                tbl_pos[free_idx]   = next_pos[snt_pkg::POS_W-1:0];
                stored_idx.push_back(free_idx);
                appends_stored++;
                a.found_position = next_pos[snt_pkg::POS_W-1:0];
            end
            snt_pkg::MODE_NAME_AT: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (tbl_valid[i] && tbl_class[i] == r.class_key &&
                        tbl_pos[i] == r.slot_position) begin
                        lookup_hits++;
                        a.hit            = 1'b1;
                        a.found_name     = tbl_name[i];
                        a.found_position = r.slot_position;
                        return a;
                    end
                end
                lookup_misses++;
            end
            snt_pkg::MODE_POS_OF: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (tbl_valid[i] && tbl_class[i] == r.class_key &&
                        tbl_name[i] == r.name_key) begin
                        lookup_hits++;
                        a.hit            = 1'b1;
                        a.found_position = tbl_pos[i];
                        return a;
                    end
                end
                lookup_misses++;
            end
            default: begin
                // unused mode answers with an all-zero word
            end
        endcase
        return a;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [snt_pkg::KEY_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // key that differs from a stored one in a single bit
    function automatic logic [snt_pkg::KEY_W-1:0] flip_one_bit(
        logic [snt_pkg::KEY_W-1:0] key);
        return key ^ (snt_pkg::KEY_W'(1) << $urandom_range(snt_pkg::KEY_W - 1));
    endfunction

    function automatic t_request make_request(logic [1:0] mode,
                                              logic [snt_pkg::KEY_W-1:0] cls,
                                              logic [snt_pkg::KEY_W-1:0] nm,
                                              logic [snt_pkg::POS_W-1:0] pos);
        t_request r;
        r.mode          = mode;
        r.class_key     = cls;
        r.name_key      = nm;
        r.slot_position = pos;
        return r;
    endfunction

    // mostly requests aimed at stored entries, so lookups hit and appends
    // repeat existing names; the rest are near misses and plain noise
    function automatic t_request make_random_request();
        t_request r;
        int       roll;
        int       pick;
        int       k;
        roll = $urandom_range(99);
        pick = $urandom_range(99);
        r    = make_request(MODE_UNUSED, rand_key(), rand_key(),
                            snt_pkg::POS_W'($urandom));
        k    = (stored_idx.size() != 0) ? stored_idx[$urandom_range(stored_idx.size() - 1)]
                                        : -1;
        if (roll < 10) begin
            r.mode      = snt_pkg::MODE_APPEND;
            r.class_key = class_pool[$urandom_range(CLASS_POOL - 1)];
            if (k >= 0 && pick < 35) begin
                r.class_key = tbl_class[k];
                r.name_key  = tbl_name[k];
            end else if (k >= 0 && pick < 45) begin
                r.class_key = tbl_class[k];
                r.name_key  = flip_one_bit(tbl_name[k]);
            end else if (pick >= 95) begin
                r.class_key = rand_key();
            end
        end else if (roll < 50) begin
            r.mode      = snt_pkg::MODE_NAME_AT;
            r.class_key = class_pool[$urandom_range(CLASS_POOL - 1)];
            if (k >= 0 && pick < 70) begin
                r.class_key     = tbl_class[k];
                r.slot_position = tbl_pos[k];
            end else if (k >= 0 && pick < 85) begin
                r.class_key = tbl_class[k];
            end else if (k >= 0 && pick < 92) begin
                r.class_key     = flip_one_bit(tbl_class[k]);
                r.slot_position = tbl_pos[k];
            end
        end else if (roll < 90) begin
            r.mode      = snt_pkg::MODE_POS_OF;
            r.class_key = class_pool[$urandom_range(CLASS_POOL - 1)];
            if (k >= 0 && pick < 65) begin
                r.class_key = tbl_class[k];
                r.name_key  = tbl_name[k];
            end else if (k >= 0 && pick < 75) begin
                r.class_key = tbl_class[k];
                r.name_key  = flip_one_bit(tbl_name[k]);
            end else if (k >= 0 && pick < 85) begin
                r.class_key = flip_one_bit(tbl_class[k]);
                r.name_key  = tbl_name[k];
            end
        end
        return r;
    endfunction

    // sends one request word, idling first at random; valid stays high when
    // the next word follows straight on
    task automatic issue_request(input t_request r);
        int gap;
        if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            // mostly short gaps, sometimes long enough to outlast a whole scan
            gap = ($urandom_range(9) == 0) ? $urandom_range(160, 4) : $urandom_range(3, 1);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.mode          <= r.mode;
        req_ch.class_key     <= r.class_key;
        req_ch.name_key      <= r.name_key;
        req_ch.slot_position <= r.slot_position;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        pending_answers.push_back(predict_table_answer(r));
    endtask

    // ------------------------------------------------------------------------
    // response side: random stalls and the word checker
    // ------------------------------------------------------------------------
    initial begin : response_ready_driver
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic void report_mismatch(string what,
                                            logic [snt_pkg::KEY_W-1:0] want_v,
                                            logic [snt_pkg::KEY_W-1:0] got_v);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
    endfunction

    always @(posedge i_clk) begin : answer_checker
        t_answer want;
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            answers_seen++;
            if (pending_answers.size() == 0) begin
                mismatch_count++;
                $display("%0t: response word mismatch, expected none, actual hit %0b name %0h pos %0d",
                         $time, rsp_ch.hit, rsp_ch.found_name, rsp_ch.found_position);
            end else begin
                want = pending_answers.pop_front();
                if (rsp_ch.hit !== want.hit)
                    report_mismatch("hit", snt_pkg::KEY_W'(want.hit),
                                    snt_pkg::KEY_W'(rsp_ch.hit));
                if (rsp_ch.found_name !== want.found_name)
                    report_mismatch("found_name", want.found_name, rsp_ch.found_name);
                if (rsp_ch.found_position !== want.found_position)
                    report_mismatch("found_position", snt_pkg::KEY_W'(want.found_position),
                                    snt_pkg::KEY_W'(rsp_ch.found_position));
                if (rsp_ch.table_full !== want.table_full)
                    report_mismatch("table_full", snt_pkg::KEY_W'(want.table_full),
                                    snt_pkg::KEY_W'(rsp_ch.table_full));
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // lookups on the table straight out of reset must all miss
    task automatic test_empty_table();
        issue_request(make_request(snt_pkg::MODE_NAME_AT, '0, '0, '0));
        issue_request(make_request(snt_pkg::MODE_NAME_AT, KEY_ONES, KEY_ONES, '1));
        issue_request(make_request(snt_pkg::MODE_POS_OF, '0, '0, '0));
    endtask

    // all-zero and all-ones keys, near misses on either key, highest position
    task automatic test_key_extremes();
        issue_request(make_request(snt_pkg::MODE_APPEND, '0, '0, '0));
        issue_request(make_request(snt_pkg::MODE_APPEND, '0, KEY_ONES, '1));
        issue_request(make_request(snt_pkg::MODE_APPEND, KEY_ONES, '0, '0));
        issue_request(make_request(snt_pkg::MODE_APPEND, KEY_ONES, KEY_ONES, '1));
        issue_request(make_request(snt_pkg::MODE_NAME_AT, '0, '0, snt_pkg::POS_W'(1)));
        // a hit whose name key is zero
        issue_request(make_request(snt_pkg::MODE_NAME_AT, KEY_ONES, KEY_ONES, '0));
        issue_request(make_request(snt_pkg::MODE_POS_OF, KEY_ONES, KEY_ONES, '1));
        issue_request(make_request(snt_pkg::MODE_POS_OF, '0,
                                   KEY_ONES ^ snt_pkg::KEY_W'(1), '0));
        issue_request(make_request(snt_pkg::MODE_POS_OF,
                                   KEY_ONES ^ (snt_pkg::KEY_W'(1) << (snt_pkg::KEY_W - 1)),
                                   KEY_ONES, '0));
        issue_request(make_request(snt_pkg::MODE_NAME_AT, '0, '0, '1));
    endtask

    // appending a name the class already holds returns its position; a name one bit away is stored anew
    task automatic test_duplicate_append();
        issue_request(make_request(snt_pkg::MODE_APPEND, '0, '0, '1));
        issue_request(make_request(snt_pkg::MODE_APPEND, KEY_ONES, KEY_ONES, '0));
        issue_request(make_request(snt_pkg::MODE_APPEND, '0, snt_pkg::KEY_W'(1), '0));
        issue_request(make_request(snt_pkg::MODE_APPEND, '0, '0, '0));
    endtask

    // the unused mode answers all-zero and touches nothing
    task automatic test_unused_mode();
        issue_request(make_request(MODE_UNUSED, '0, '0, '0));
        issue_request(make_request(MODE_UNUSED, KEY_ONES, KEY_ONES, '1));
        issue_request(make_request(MODE_UNUSED, '0, '0, snt_pkg::POS_W'(1)));
    endtask

    task automatic test_random_traffic();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle = (n >= QUIET_FROM && n < QUIET_TO);
            issue_request(make_random_request());
        end
        no_idle = 1'b0;
    endtask

    // fills every remaining entry, then keeps appending into the full table, mixed with random requests;
    // at this size a class can only reach the top position by owning the whole
    // table, so the out-of-positions refusal shows up together with the full one
    task automatic test_full_table();
        int k;
        while (stored_idx.size() < ENTRIES)
            issue_request(make_request(snt_pkg::MODE_APPEND,
                                       class_pool[$urandom_range(CLASS_POOL - 1)],
                                       rand_key(), snt_pkg::POS_W'($urandom)));
        for (int n = 0; n < 48; n++) begin
            k = stored_idx[$urandom_range(stored_idx.size() - 1)];
            case (n % 3)
                0: begin
                    issue_request(make_request(snt_pkg::MODE_APPEND,
                                               ($urandom_range(1)) ? rand_key() : tbl_class[k],
                                               rand_key(), snt_pkg::POS_W'($urandom)));
                end
                1: begin
                    issue_request(make_request(snt_pkg::MODE_APPEND, tbl_class[k],
                                               tbl_name[k], snt_pkg::POS_W'($urandom)));
                end
                default: begin
                    issue_request(make_random_request());
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : test_sequence
        for (int i = 0; i < ENTRIES; i++)
            tbl_valid[i] = 1'b0;
        no_idle       = 1'b0;
        class_pool[0] = '0;
        class_pool[1] = KEY_ONES;
        for (int i = 2; i < CLASS_POOL; i++)
            class_pool[i] = rand_key();

        i_rst_n              <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.mode          <= '0;
        req_ch.class_key     <= '0;
        req_ch.name_key      <= '0;
        req_ch.slot_position <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_key_extremes();
        test_duplicate_append();
        test_unused_mode();
        test_random_traffic();
        test_full_table();

        req_ch.valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        // more quiet time, longer than a full scan, to catch a stray response word
        repeat (ENTRIES + 8) @(posedge i_clk);

        $display("%0d response words checked: %0d names stored, %0d repeat appends, %0d refused",
                 answers_seen, appends_stored, appends_repeat, appends_refused);
        $display("lookups: %0d hits, %0d misses; table ended with %0d of %0d entries in use",
                 lookup_hits, lookup_misses, stored_idx.size(), ENTRIES);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/snt_pkg.sv
rtl/snt_if.sv
rtl/snt_entry_ram.sv
rtl/slot_name_table.sv
rtl/snt_checker.sv
verif/tb_slot_name_table.sv
